// ===== hdl/bsb_pkg.sv =====
// Package for the box screen bounds projection block: widths, constants, types.
// No dependencies.
`default_nettype none
package bsb_pkg;
  localparam int COEF_FRAC_BITS_DEF  = 16;
  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int NUM_COEF  = 12;
  localparam int CIDX_W    = 4;
  localparam int COORD_W   = 24;
  localparam int EDGE_W    = 20;
  localparam int DIM_W     = 14;
  localparam int DOT_W     = 64;
  localparam int RATIO_W   = 38;   // signed, 16 fraction bits, |r| <= 2^36
  localparam int QBITS     = 37;   // 21 integer bits + 16 fraction bits
  localparam int SCR_W     = 56;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BOX  = 1'b1;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_DOT, ST_CHECK, ST_DIVX, ST_DIVY, ST_SCREEN,
    ST_NEXT, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       start;      // latch box, reset bounds, corner 0
    logic       dot_start;  // begin dot products for current corner
    logic       div_start_x;
    logic       div_start_y;
    logic       screen;     // fold screen coordinates into bounds
    logic       next_corner;
    logic       invisible;  // mark result not visible
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dot_done;
    logic w_low;
    logic div_done;
    logic last_corner;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== hdl/bsb_datapath.sv =====
// Datapath: coefficient store, serial dot-product MAC, restoring divider,
// screen mapping and bounds registers. Depends on bsb_pkg.
`default_nettype none
module bsb_datapath #(
  parameter int COEF_FRAC_BITS  = bsb_pkg::COEF_FRAC_BITS_DEF,
  parameter int COORD_FRAC_BITS = bsb_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          load_i,
  input  wire [bsb_pkg::CIDX_W-1:0]    coef_index_i,
  input  wire signed [31:0]            coef_value_i,
  input  wire [6*bsb_pkg::COORD_W-1:0] box_i,
  input  wire [bsb_pkg::DIM_W-1:0]     width_i,
  input  wire [bsb_pkg::DIM_W-1:0]     height_i,
  input  wire bsb_pkg::dp_cmd_t        cmd_i,
  output bsb_pkg::dp_sts_t             sts_o,
  output logic                         visible_o,
  output logic [bsb_pkg::EDGE_W-1:0]   left_edge_o,
  output logic [bsb_pkg::EDGE_W-1:0]   top_edge_o,
  output logic [bsb_pkg::EDGE_W-1:0]   right_edge_o,
  output logic [bsb_pkg::EDGE_W-1:0]   bottom_edge_o
);
  import bsb_pkg::*;

  localparam logic signed [DOT_W-1:0] WMIN =
    DOT_W'((2**COEF_FRAC_BITS / 100) * (2**COORD_FRAC_BITS));
  localparam int SHIFT = 17 - COORD_FRAC_BITS;

  // coefficient store
  logic signed [31:0] coef_q [NUM_COEF];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
    end else if (load_i && coef_index_i < CIDX_W'(NUM_COEF)) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // box and corner
  logic [6*COORD_W-1:0] box_q;
  logic [2:0]           corner_q;
  logic signed [COORD_W-1:0] px, py, pz;
  always_comb begin
    px = corner_q[0] ? box_q[4*COORD_W-1 -: COORD_W] : box_q[COORD_W-1:0];
    py = corner_q[1] ? box_q[5*COORD_W-1 -: COORD_W] : box_q[2*COORD_W-1 -: COORD_W];
    pz = corner_q[2] ? box_q[6*COORD_W-1 -: COORD_W] : box_q[3*COORD_W-1 -: COORD_W];
  end

  // serial MAC: step = row*4 + col over rows 0..2
  logic [3:0] step_q;
  logic       mac_busy_q;
  logic signed [DOT_W-1:0] acc_q, dx_q, dy_q, dw_q;
  logic signed [COORD_W:0] operand;
  logic signed [DOT_W-1:0] prod;
  always_comb begin
    unique case (step_q[1:0])
      2'd0:    operand = {px[COORD_W-1], px};
      2'd1:    operand = {py[COORD_W-1], py};
      2'd2:    operand = {pz[COORD_W-1], pz};
      default: operand = (COORD_W+1)'(2**COORD_FRAC_BITS);
    endcase
    prod = DOT_W'(coef_q[step_q]) * DOT_W'(operand);
  end
  logic signed [DOT_W-1:0] prod_q;
  logic                    prod_v_q, prod_last_q;
  logic [1:0]              prod_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_busy_q <= 1'b0;
      prod_v_q   <= 1'b0;
      step_q     <= '0;
    end else begin
      prod_v_q <= mac_busy_q;
      if (cmd_i.dot_start) begin
        mac_busy_q <= 1'b1;
        step_q     <= '0;
      end else if (mac_busy_q) begin
        if (step_q == 4'd11) mac_busy_q <= 1'b0;
        else step_q <= step_q + 4'd1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    prod_q      <= prod;
    prod_last_q <= (step_q[1:0] == 2'd3);
    prod_row_q  <= step_q[3:2];
    if (cmd_i.dot_start) acc_q <= '0;
    else if (prod_v_q) begin
      if (prod_last_q) begin
        acc_q <= '0;
        unique case (prod_row_q)
          2'd0:    dx_q <= acc_q + prod_q;
          2'd1:    dy_q <= acc_q + prod_q;
          default: dw_q <= acc_q + prod_q;
        endcase
      end else acc_q <= acc_q + prod_q;
    end
  end
  logic dot_done;
  assign dot_done = prod_v_q && prod_last_q && (prod_row_q == 2'd2);

  // restoring divider, one quotient bit a cycle
  logic [DOT_W-1:0]  num_q, rem_q;
  logic [QBITS-1:0]  quo_q;
  logic [5:0]        dcnt_q;
  logic              div_busy_q, div_done_q, dneg_q;
  logic [DOT_W:0]    rem_sh;
  logic [DOT_W-1:0]  den;
  assign den    = dw_q;
  assign rem_sh = {rem_q, num_q[DOT_W-1]};
  logic signed [DOT_W-1:0] dsrc;
  assign dsrc = cmd_i.div_start_x ? dx_q : dy_q;

  // integer part uses bits above 2^20 guard; quotient capped at 2^36
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
    end else begin
      div_done_q <= 1'b0;
      if (cmd_i.div_start_x || cmd_i.div_start_y) div_busy_q <= 1'b1;
      else if (div_busy_q && dcnt_q == 6'd0) begin
        div_busy_q <= 1'b0;
        div_done_q <= 1'b1;
      end
    end
  end
  // numerator is |n| (<= 2^63); quotient bits generated MSB first: the numerator is
  // shifted through 64 integer steps, then 16 fraction steps.
  logic [6:0] istep_q;
  logic       sat_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start_x || cmd_i.div_start_y) begin
      dneg_q  <= dsrc[DOT_W-1];
      num_q   <= dsrc[DOT_W-1] ? DOT_W'(-dsrc) : DOT_W'(dsrc);
      rem_q   <= '0;
      quo_q   <= '0;
      sat_q   <= 1'b0;
      istep_q <= 7'd80;
      dcnt_q  <= 6'd1;
    end else if (div_busy_q && istep_q != 7'd0) begin
      num_q   <= num_q << 1;
      istep_q <= istep_q - 7'd1;
      if (rem_sh >= {1'b0, den}) begin
        rem_q <= DOT_W'(rem_sh - {1'b0, den});
        if (quo_q[QBITS-1 -: 17] != '0 && istep_q > 7'd16) sat_q <= 1'b1;
        quo_q <= {quo_q[QBITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DOT_W-1:0];
        if (quo_q[QBITS-1 -: 17] != '0 && istep_q > 7'd16) sat_q <= 1'b1;
        quo_q <= {quo_q[QBITS-2:0], 1'b0};
      end
    end
    if (!(cmd_i.div_start_x || cmd_i.div_start_y))
      dcnt_q <= (div_busy_q && istep_q == 7'd1) ? 6'd0 : dcnt_q;
  end
  // magnitude >= 2^20 integer -> 2^36
  logic [QBITS-1:0] qmag;
  assign qmag = (sat_q || (quo_q >> 36) != '0) ? (QBITS'(1) << 36) : quo_q;
  logic signed [RATIO_W-1:0] ratio_val;
  assign ratio_val = dneg_q ? -RATIO_W'(qmag) : RATIO_W'(qmag);

  // steer each finished ratio to x or y
  logic rx_sel_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rx_sel_q <= 1'b0;
    else if (cmd_i.div_start_x) rx_sel_q <= 1'b1;
    else if (cmd_i.div_start_y) rx_sel_q <= 1'b0;
  end
  logic signed [RATIO_W-1:0] rx_q, ry_q;
  always_ff @(posedge clk_i) begin
    if (div_done_q) begin
      if (rx_sel_q) rx_q <= ratio_val;
      else          ry_q <= -ratio_val;
    end
  end

  // screen mapping, floor shift
  logic signed [SCR_W-1:0] px_s, py_s, sx, sy;
  assign px_s = SCR_W'($signed({1'b0, width_i}))  * (SCR_W'(65536) + SCR_W'(rx_q));
  assign py_s = SCR_W'($signed({1'b0, height_i})) * (SCR_W'(65536) + SCR_W'(ry_q));
  assign sx = px_s >>> SHIFT;
  assign sy = py_s >>> SHIFT;

  // bounds
  logic signed [SCR_W-1:0] left_q, top_q, right_q, bottom_q;
  logic                    vis_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      box_q    <= box_i;
      corner_q <= '0;
      left_q   <= SCR_W'(width_i)  <<< COORD_FRAC_BITS;
      top_q    <= SCR_W'(height_i) <<< COORD_FRAC_BITS;
      right_q  <= '0;
      bottom_q <= '0;
      vis_q    <= 1'b1;
    end else begin
      if (cmd_i.next_corner) corner_q <= corner_q + 3'd1;
      if (cmd_i.invisible) vis_q <= 1'b0;
      if (cmd_i.screen) begin
        if (sx < left_q)   left_q   <= sx;
        if (sy < top_q)    top_q    <= sy;
        if (sx > right_q)  right_q  <= sx;
        if (sy > bottom_q) bottom_q <= sy;
      end
    end
  end

  function automatic logic [EDGE_W-1:0] sat_edge(input logic signed [SCR_W-1:0] v);
    if (v > SCR_W'(2**(EDGE_W-1) - 1))        sat_edge = {1'b0, {(EDGE_W-1){1'b1}}};
    else if (v < -SCR_W'(2**(EDGE_W-1)))      sat_edge = {1'b1, {(EDGE_W-1){1'b0}}};
    else                                      sat_edge = v[EDGE_W-1:0];
  endfunction

  assign visible_o     = vis_q;
  assign left_edge_o   = vis_q ? sat_edge(left_q)   : '0;
  assign top_edge_o    = vis_q ? sat_edge(top_q)    : '0;
  assign right_edge_o  = vis_q ? sat_edge(right_q)  : '0;
  assign bottom_edge_o = vis_q ? sat_edge(bottom_q) : '0;

  assign sts_o.dot_done    = dot_done;
  assign sts_o.w_low       = (dw_q < WMIN);
  assign sts_o.div_done    = div_done_q;
  assign sts_o.last_corner = (corner_q == 3'd7);
endmodule
`default_nettype wire

// ===== hdl/bsb_ctrl.sv =====
// Controller state machine sequencing corners through MAC, divider and bounds.
// Depends on bsb_pkg.
`default_nettype none
module bsb_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               box_req_i,
  input  wire               out_taken_i,
  input  wire bsb_pkg::dp_sts_t sts_i,
  output bsb_pkg::dp_cmd_t  cmd_o,
  output logic              idle_o,
  output logic              out_valid_o
);
  import bsb_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (box_req_i) begin
          cmd_o.start = 1'b1;
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd_o.dot_start = 1'b1;
        state_d = ST_DOT;
      end
      ST_DOT:   if (sts_i.dot_done) state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.w_low) begin
          cmd_o.invisible = 1'b1;
          state_d = ST_OUT;
        end else begin
          cmd_o.div_start_x = 1'b1;
          state_d = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (sts_i.div_done) begin
          cmd_o.div_start_y = 1'b1;
          state_d = ST_DIVY;
        end
      end
      ST_DIVY:   if (sts_i.div_done) state_d = ST_SCREEN;
      ST_SCREEN: begin
        cmd_o.screen = 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (sts_i.last_corner) state_d = ST_OUT;
        else begin
          cmd_o.next_corner = 1'b1;
          state_d = ST_CLEAR;
        end
      end
      ST_OUT:  if (out_taken_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
endmodule
`default_nettype wire

// ===== hdl/box_screen_bounds_projection.sv =====
// Box screen bounds projection top level: stream ports, APB registers.
// Each corner runs the dot products, then the 80-step restoring divider twice (x, then y);
// a hidden box skips straight to the result. A load request is written on acceptance
// and leaves the block idle. One box at a time: the next request is accepted
// the cycle after the result is taken. Reset (asynchronous, rst_ni low) clears the
// coefficient store, sets width 1920, height 1080. Uses bsb_pkg, bsb_ctrl, bsb_datapath.
`default_nettype none
module box_screen_bounds_projection #(
  parameter int COEF_FRAC_BITS  = bsb_pkg::COEF_FRAC_BITS_DEF,
  parameter int COORD_FRAC_BITS = bsb_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: coef_index[3:0], coef_value[35:4], min_x, min_y, min_z, max_x, max_y, max_z
  input  wire [183:0] s_axis_tdata,
  input  wire         s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: visible[0], left_edge[20:1], top_edge[40:21], right[60:41], bottom[80:61]
  output logic [87:0] m_axis_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [2:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsb_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] width_q, height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1920);
      height_q <= DIM_W'(1080);
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_WIDTH:  prdata = 32'(width_q);
        REG_HEIGHT: prdata = 32'(height_q);
        default:    prdata = '0;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic idle, accept, load, box_req;
  assign s_axis_tready = idle;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign load    = accept && (s_axis_tuser == CMD_LOAD);
  assign box_req = accept && (s_axis_tuser == CMD_BOX);

  bsb_ctrl u_ctrl (
    .clk_i, .rst_ni, .box_req_i(box_req),
    .out_taken_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd),
    .idle_o(idle), .out_valid_o(m_axis_tvalid)
  );

  logic vis;
  logic [EDGE_W-1:0] le, te, re, be;
  bsb_datapath #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .load_i(load),
    .coef_index_i(s_axis_tdata[3:0]), .coef_value_i(s_axis_tdata[35:4]),
    .box_i(s_axis_tdata[179:36]), .width_i(width_q), .height_i(height_q),
    .cmd_i(cmd), .sts_o(sts), .visible_o(vis),
    .left_edge_o(le), .top_edge_o(te), .right_edge_o(re), .bottom_edge_o(be)
  );

  assign m_axis_tdata = {7'd0, be, re, te, le, vis};

  // hold the result while it waits
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  // never take a request while a result is offered
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid));
  // a hidden box carries zero edges
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[80:1] == '0);
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready);
endmodule
`default_nettype wire
